// ===== rtl/hsv_to_rgb_converter_assert.svh =====
// Assertion macros for the HSV to RGB converter.
// HSVRGB_ASSERT_NOW: same-cycle implication; HSVRGB_ASSERT_NEXT: next-cycle implication.
`ifndef HSV_TO_RGB_CONVERTER_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_ASSERT_SVH

`ifndef SYNTH
`define HSVRGB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hsv_to_rgb_converter: same-cycle check failed");
`define HSVRGB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hsv_to_rgb_converter: next-cycle check failed");
`else
`define HSVRGB_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define HSVRGB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/hsvrgb_pkg.sv =====
`default_nettype none

package hsvrgb_pkg;

	localparam int FRAC_BITS            = 14;
	localparam int HUE_STEPS_PER_DEGREE = 16;

	localparam int IN_W  = 16;
	localparam int OUT_W = 15;
	localparam int ONE_W = FRAC_BITS + 1;
	localparam logic [ONE_W-1:0] ONE = ONE_W'(1) << FRAC_BITS;

	localparam int SECTORS     = 6;
	localparam int SECTOR_SPAN = 60 * HUE_STEPS_PER_DEGREE;
	localparam int FULL_TURN   = SECTORS * SECTOR_SPAN;
	localparam int SEC_W       = $clog2(SECTORS);
	localparam int TURN_W      = $clog2(FULL_TURN);
	localparam int SPAN_W      = $clog2(SECTOR_SPAN);

	// hue is biased by a whole number of turns so the wrap works on a positive value
	localparam int HUE_OFFSET = FULL_TURN * ((2**(IN_W-1) + FULL_TURN - 1) / FULL_TURN);
	localparam int U_MAX      = 2**(IN_W-1) - 1 + HUE_OFFSET;
	localparam int U_W        = $clog2(U_MAX + 1);
	localparam int QT_W       = $clog2(U_MAX / FULL_TURN + 1);

	// reciprocal constants: floor(n / d) = (n * K) >> SH
	localparam int TURN_SH   = U_W + TURN_W + 1;
	localparam int TURN_K_W  = TURN_SH - TURN_W + 2;
	localparam longint unsigned TURN_K =
		((64'd1 << TURN_SH) + FULL_TURN - 1) / FULL_TURN;

	localparam int SEC_SH    = TURN_W + SPAN_W + 1;
	localparam int SEC_K_W   = SEC_SH - SPAN_W + 2;
	localparam longint unsigned SEC_K =
		((64'd1 << SEC_SH) + SECTOR_SPAN - 1) / SECTOR_SPAN;

	localparam int FRAC_SH   = 2 * SPAN_W + FRAC_BITS + 1;
	localparam int FRAC_K_W  = FRAC_SH - SPAN_W + 2;
	localparam int FRAC_DROP = FRAC_SH - FRAC_BITS;
	localparam longint unsigned FRAC_K =
		((64'd1 << FRAC_SH) + SECTOR_SPAN - 1) / SECTOR_SPAN;

	typedef enum logic [SEC_W-1:0] {
		SEC_RED_YELLOW    = 3'd0,
		SEC_YELLOW_GREEN  = 3'd1,
		SEC_GREEN_CYAN    = 3'd2,
		SEC_CYAN_BLUE     = 3'd3,
		SEC_BLUE_MAGENTA  = 3'd4,
		SEC_MAGENTA_RED   = 3'd5
	} sector_t;

	typedef struct packed {
		logic signed [IN_W-1:0] hue;
		logic signed [IN_W-1:0] saturation;
		logic signed [IN_W-1:0] brightness;
	} hsv_t;

	typedef struct packed {
		logic [OUT_W-1:0] red;
		logic [OUT_W-1:0] green;
		logic [OUT_W-1:0] blue;
	} rgb_t;

endpackage

`default_nettype wire

// ===== rtl/hsvrgb_stream_if.sv =====
`default_nettype none

interface hsvrgb_stream_if #(
	parameter type data_t = logic
);
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/hsv_to_rgb_converter.sv =====
// HSV to RGB colour converter.
// Channels: hsv (sink, payload hsvrgb_pkg::hsv_t) and rgb (source, payload
// hsvrgb_pkg::rgb_t), valid/ready; a transaction completes on a clock edge
// with valid and ready both high.
// Hue is in 1/16 degree and wraps over a full turn; saturation and value are
// Q14 and are clamped to 0..1. Outputs are Q14.
// Eight register stages: turn count, hue wrap, sector split, sector remainder,
// fraction, the two products s*f, and the final v products, then the sector
// routing into the output register. Each stage holds at most two multipliers.
// Throughput: one transaction per cycle while rgb is not stalled, with no
// dependence between items.
// Stall: each stage moves on when it is empty or its successor moves, so
// bubbles close up; hsv.ready falls only when all eight stages hold items
// and rgb is stalled. Nothing is lost or repeated.
// Reset clears the stage valid bits only; the block is ready at once.
`default_nettype none

`include "hsv_to_rgb_converter_assert.svh"

module hsv_to_rgb_converter (
	input  logic            clk,
	input  logic            arst_n,
	hsvrgb_stream_if.sink   hsv,
	hsvrgb_stream_if.source rgb
);
	import hsvrgb_pkg::*;

	localparam int STAGES = 8;

	localparam logic [TURN_K_W-1:0] TURN_K_C = TURN_K_W'(TURN_K);
	localparam logic [SEC_K_W-1:0]  SEC_K_C  = SEC_K_W'(SEC_K);
	localparam logic [FRAC_K_W-1:0] FRAC_K_C = FRAC_K_W'(FRAC_K);

	function automatic logic [ONE_W-1:0] clamp_unit(input logic signed [IN_W-1:0] x);
		logic [31:0] ext;
		ext = 32'($unsigned(x));
		if (x < 0) begin
			return '0;
		end else if (ext > 32'(ONE)) begin
			return ONE;
		end
		return ONE_W'(ext);
	endfunction

	logic [STAGES:1] vld_q;
	logic [STAGES:1] load;

	// pipeline registers
	logic [U_W-1:0]    u_s1;
	logic [QT_W-1:0]   qt_s1;
	logic [ONE_W-1:0]  s_s1, s_s2, s_s3, s_s4, s_s5;
	logic [ONE_W-1:0]  v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic [TURN_W-1:0] h_s2, h_s3;
	logic [ONE_W-1:0]  p_s2, p_s3, p_s4, p_s5, p_s6, p_s7;
	sector_t           sec_s3, sec_s4, sec_s5, sec_s6, sec_s7;
	logic [SPAN_W-1:0] rem_s4;
	logic [FRAC_BITS-1:0] f_s5;
	logic [ONE_W-1:0]  sf_s6, sfc_s6;
	logic [ONE_W-1:0]  q_s7, t_s7;
	rgb_t              rgb_s8;

	// stage logic
	logic [U_W-1:0]             hue_u;
	logic [U_W+TURN_K_W-1:0]    turn_prod;
	logic [U_W-1:0]             turn_base;
	logic [2*ONE_W-1:0]         p_prod;
	logic [TURN_W+SEC_K_W-1:0]  sec_prod;
	logic [TURN_W-1:0]          sec_base;
	logic [SPAN_W+FRAC_K_W-1:0] frac_prod;
	logic [ONE_W-1:0]           f_ext, f_cmp;
	logic [2*ONE_W-1:0]         sf_prod, sfc_prod;
	logic [2*ONE_W-1:0]         q_prod, t_prod;
	logic [ONE_W-1:0]           r_sel, g_sel, b_sel;

	// flow control
	assign load[STAGES] = !vld_q[STAGES] || rgb.ready;
	for (genvar k = 1; k < STAGES; k++) begin : g_load
		assign load[k] = !vld_q[k] || load[k+1];
	end

	assign hsv.ready = load[1];
	assign rgb.valid = vld_q[STAGES];
	assign rgb.data  = rgb_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (load[1]) begin
				vld_q[1] <= hsv.valid;
			end
			for (int k = 2; k <= STAGES; k++) begin
				if (load[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// s1: bias hue and find the turn count
	assign hue_u     = U_W'(32'(hsv.data.hue) + 32'(HUE_OFFSET));
	assign turn_prod = {{TURN_K_W{1'b0}}, hue_u} * {{U_W{1'b0}}, TURN_K_C};

	always_ff @(posedge clk) begin
		if (load[1]) begin
			u_s1  <= hue_u;
			qt_s1 <= turn_prod[TURN_SH +: QT_W];
			s_s1  <= clamp_unit(hsv.data.saturation);
			v_s1  <= clamp_unit(hsv.data.brightness);
		end
	end

	// s2: wrapped hue, p = v(1-s)
	assign turn_base = U_W'(qt_s1) * U_W'(FULL_TURN);
	assign p_prod    = {{ONE_W{1'b0}}, v_s1} * {{ONE_W{1'b0}}, ONE - s_s1};

	always_ff @(posedge clk) begin
		if (load[2]) begin
			h_s2 <= TURN_W'(u_s1 - turn_base);
			p_s2 <= p_prod[FRAC_BITS +: ONE_W];
			s_s2 <= s_s1;
			v_s2 <= v_s1;
		end
	end

	// s3: sector
	assign sec_prod = {{SEC_K_W{1'b0}}, h_s2} * {{TURN_W{1'b0}}, SEC_K_C};

	always_ff @(posedge clk) begin
		if (load[3]) begin
			sec_s3 <= sector_t'(sec_prod[SEC_SH +: SEC_W]);
			h_s3   <= h_s2;
			s_s3   <= s_s2;
			v_s3   <= v_s2;
			p_s3   <= p_s2;
		end
	end

	// s4: remainder within the sector
	assign sec_base = TURN_W'(sec_s3) * TURN_W'(SECTOR_SPAN);

	always_ff @(posedge clk) begin
		if (load[4]) begin
			rem_s4 <= SPAN_W'(h_s3 - sec_base);
			sec_s4 <= sec_s3;
			s_s4   <= s_s3;
			v_s4   <= v_s3;
			p_s4   <= p_s3;
		end
	end

	// s5: fraction f = rem * ONE / span
	assign frac_prod = {{FRAC_K_W{1'b0}}, rem_s4} * {{SPAN_W{1'b0}}, FRAC_K_C};

	always_ff @(posedge clk) begin
		if (load[5]) begin
			f_s5   <= frac_prod[FRAC_DROP +: FRAC_BITS];
			sec_s5 <= sec_s4;
			s_s5   <= s_s4;
			v_s5   <= v_s4;
			p_s5   <= p_s4;
		end
	end

	// s6: s*f and s*(1-f)
	assign f_ext    = {1'b0, f_s5};
	assign f_cmp    = ONE - f_ext;
	assign sf_prod  = {{ONE_W{1'b0}}, s_s5} * {{ONE_W{1'b0}}, f_ext};
	assign sfc_prod = {{ONE_W{1'b0}}, s_s5} * {{ONE_W{1'b0}}, f_cmp};

	always_ff @(posedge clk) begin
		if (load[6]) begin
			sf_s6  <= sf_prod[FRAC_BITS +: ONE_W];
			sfc_s6 <= sfc_prod[FRAC_BITS +: ONE_W];
			sec_s6 <= sec_s5;
			v_s6   <= v_s5;
			p_s6   <= p_s5;
		end
	end

	// s7: q and t
	assign q_prod = {{ONE_W{1'b0}}, v_s6} * {{ONE_W{1'b0}}, ONE - sf_s6};
	assign t_prod = {{ONE_W{1'b0}}, v_s6} * {{ONE_W{1'b0}}, ONE - sfc_s6};

	always_ff @(posedge clk) begin
		if (load[7]) begin
			q_s7   <= q_prod[FRAC_BITS +: ONE_W];
			t_s7   <= t_prod[FRAC_BITS +: ONE_W];
			sec_s7 <= sec_s6;
			v_s7   <= v_s6;
			p_s7   <= p_s6;
		end
	end

	// s8: route by sector; zero saturation gives p = q = t = v
	always_comb begin
		case (sec_s7)
			SEC_RED_YELLOW: begin
				r_sel = v_s7; g_sel = t_s7; b_sel = p_s7;
			end
			SEC_YELLOW_GREEN: begin
				r_sel = q_s7; g_sel = v_s7; b_sel = p_s7;
			end
			SEC_GREEN_CYAN: begin
				r_sel = p_s7; g_sel = v_s7; b_sel = t_s7;
			end
			SEC_CYAN_BLUE: begin
				r_sel = p_s7; g_sel = q_s7; b_sel = v_s7;
			end
			SEC_BLUE_MAGENTA: begin
				r_sel = t_s7; g_sel = p_s7; b_sel = v_s7;
			end
			default: begin
				r_sel = v_s7; g_sel = p_s7; b_sel = q_s7;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load[8]) begin
			rgb_s8.red   <= OUT_W'(r_sel);
			rgb_s8.green <= OUT_W'(g_sel);
			rgb_s8.blue  <= OUT_W'(b_sel);
		end
	end

	`HSVRGB_ASSERT_NEXT(a_accept_enters, clk, arst_n, hsv.valid && hsv.ready, vld_q[1])
	`HSVRGB_ASSERT_NOW(a_stall_only_full, clk, arst_n, !hsv.ready, &vld_q)
	`HSVRGB_ASSERT_NEXT(a_no_phantom, clk, arst_n, rgb.valid && rgb.ready && !vld_q[STAGES-1], !rgb.valid)

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import hsvrgb_pkg::*;

	localparam longint unsigned UNIT = 64'd1 << FRAC_BITS;

	logic clk = 1'b0;
	logic arst_n;

	hsvrgb_stream_if #(.data_t(hsv_t)) hsv_ch ();
	hsvrgb_stream_if #(.data_t(rgb_t)) rgb_ch ();

	hsv_to_rgb_converter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.hsv    (hsv_ch),
		.rgb    (rgb_ch)
	);

	rgb_t rgb_expected[$];
	int   error_count = 0;
	int   shown_count = 0;
	bit   idle_on     = 1'b1;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic longint unsigned clamp_unit(logic signed [IN_W-1:0] x);
		if (x < 0)
			return 0;
		if (longint'(x) > longint'(UNIT))
			return UNIT;
		return longint'(x);
	endfunction

	function automatic rgb_t predict_rgb(hsv_t px);
		int                h;
		int                rem;
		longint unsigned   s, v, f, p, q, t, r, g, b;
		sector_t           sec;
		rgb_t              res;
		h = int'(px.hue) % FULL_TURN;
		if (h < 0)
			h += FULL_TURN;
		s = clamp_unit(px.saturation);
		v = clamp_unit(px.brightness);
		if (s == 0) begin
			r = v;
			g = v;
			b = v;
		end else begin
			sec = sector_t'(h / SECTOR_SPAN);
			rem = h % SECTOR_SPAN;
			f = (longint'(rem) << FRAC_BITS) / SECTOR_SPAN;
			p = (v * (UNIT - s)) >> FRAC_BITS;
			q = (v * (UNIT - ((s * f) >> FRAC_BITS))) >> FRAC_BITS;
			t = (v * (UNIT - ((s * (UNIT - f)) >> FRAC_BITS))) >> FRAC_BITS;
			case (sec)
				SEC_RED_YELLOW: begin
					r = v; g = t; b = p;
				end
				SEC_YELLOW_GREEN: begin
					r = q; g = v; b = p;
				end
				SEC_GREEN_CYAN: begin
					r = p; g = v; b = t;
				end
				SEC_CYAN_BLUE: begin
					r = p; g = q; b = v;
				end
				SEC_BLUE_MAGENTA: begin
					r = t; g = p; b = v;
				end
				default: begin
					r = v; g = p; b = q;
				end
			endcase
		end
		res.red   = OUT_W'(r);
		res.green = OUT_W'(g);
		res.blue  = OUT_W'(b);
		return res;
	endfunction

	task automatic send_hsv(input int hue, input int sat, input int val);
		int   gap;
		hsv_t px;
		px.hue        = IN_W'(hue);
		px.saturation = IN_W'(sat);
		px.brightness = IN_W'(val);
		gap = idle_on ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			hsv_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		hsv_ch.valid <= 1'b1;
		hsv_ch.data  <= px;
		do
			@(posedge clk);
		while (hsv_ch.ready !== 1'b1);
		rgb_expected.push_back(predict_rgb(px));
	endtask

	function automatic int rand_unit_range();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return 0;
		if (pick == 1)
			return int'(UNIT);
		return $urandom_range(0, int'(UNIT));
	endfunction

	function automatic int rand_raw16();
		return int'($signed(16'($urandom)));
	endfunction

	// result checker and sink-side stalls
	initial begin
		int   stall_left;
		rgb_t exp_rgb;
		rgb_t got_rgb;
		stall_left = 0;
		rgb_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rgb_ch.valid === 1'b1 && rgb_ch.ready === 1'b1) begin
				got_rgb = rgb_ch.data;
				if (rgb_expected.size() == 0) begin
					error_count++;
					if (shown_count < 10) begin
						shown_count++;
						$display("unexpected transaction: r=%0d g=%0d b=%0d",
							got_rgb.red, got_rgb.green, got_rgb.blue);
					end
				end else begin
					exp_rgb = rgb_expected.pop_front();
					if (got_rgb.red !== exp_rgb.red || got_rgb.green !== exp_rgb.green ||
							got_rgb.blue !== exp_rgb.blue) begin
						error_count++;
						if (shown_count < 10) begin
							shown_count++;
							$display("mismatch: exp r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
								exp_rgb.red, exp_rgb.green, exp_rgb.blue,
								got_rgb.red, got_rgb.green, got_rgb.blue);
						end
					end
				end
				stall_left = idle_on ? $urandom_range(0, 4) : 0;
			end else if (stall_left > 0) begin
				stall_left--;
			end
			rgb_ch.ready <= (stall_left == 0);
		end
	end

	task automatic test_sector_edges();
		for (int k = 0; k < SECTORS; k++)
			send_hsv(k * SECTOR_SPAN, int'(UNIT), int'(UNIT));
		send_hsv(SECTOR_SPAN - 1, int'(UNIT), 12000);
		send_hsv(SECTOR_SPAN / 2, 8192, 10000);
		send_hsv(FULL_TURN - 1, 9000, int'(UNIT));
	endtask

	task automatic test_hue_wrap();
		send_hsv(FULL_TURN, int'(UNIT), int'(UNIT));
		send_hsv(-1, int'(UNIT), int'(UNIT));
		send_hsv(-32768, 16000, 15000);
		send_hsv(32767, 12345, 16383);
	endtask

	task automatic test_gray();
		send_hsv(2000, 0, 12345);
		send_hsv(4000, -5, int'(UNIT));
		send_hsv(-32768, -32768, 32767);
	endtask

	task automatic test_clamping();
		send_hsv(1000, int'(UNIT) + 1, -1);
		send_hsv(3000, 32767, int'(UNIT));
		send_hsv(5000, 8000, 0);
		send_hsv(500, int'(UNIT), -32768);
		send_hsv(2500, 1, 1);
		send_hsv(4500, 20000, 32767);
	endtask

	task automatic test_random_colours(input int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 3) == 0)
				send_hsv(rand_raw16(), rand_unit_range(), rand_unit_range());
			else
				send_hsv($urandom_range(0, FULL_TURN - 1), rand_unit_range(),
					rand_unit_range());
		end
	endtask

	task automatic test_random_raw(input int count);
		for (int i = 0; i < count; i++)
			send_hsv(rand_raw16(), rand_raw16(), rand_raw16());
	endtask

	task automatic test_streaming(input int count);
		idle_on = 1'b0;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 1) == 0)
				send_hsv(rand_raw16(), rand_raw16(), rand_raw16());
			else
				send_hsv(rand_raw16(), rand_unit_range(), rand_unit_range());
		end
		idle_on = 1'b1;
	endtask

	initial begin
		arst_n       <= 1'b0;
		hsv_ch.valid <= 1'b0;
		hsv_ch.data  <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_sector_edges();
		test_hue_wrap();
		test_gray();
		test_clamping();
		test_random_colours(200);
		test_streaming(60);
		test_random_raw(150);
		test_streaming(40);
		test_random_colours(100);

		hsv_ch.valid <= 1'b0;
		while (rgb_expected.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (error_count == 0 && rgb_expected.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#2000000;
		$display("status: fail");
		$finish;
	end

endmodule
